// ----- hw/rtl/sha1s_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1s_pkg
// shared types, constants and round functions of the sha-1 stream hasher
// ----------------------------------------------------------------------------
package sha1s_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int ROUNDS      = 80;
   localparam int ROUND_W     = 7;

   localparam logic [31:0] SHA1S_INIT [5] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   localparam logic [31:0] K_ROUND_0 = 32'h5a827999;
   localparam logic [31:0] K_ROUND_1 = 32'h6ed9eba1;
   localparam logic [31:0] K_ROUND_2 = 32'h8f1bbcdc;
   localparam logic [31:0] K_ROUND_3 = 32'hca62c1d6;
   localparam logic [7:0]  PAD_BYTE  = 8'h80;

   localparam logic MODE_DATA   = 1'b0;
   localparam logic MODE_FINISH = 1'b1;

   // one message word moving from the front to the round engine
   typedef struct packed {
      logic        last_word;   // closing word of the final padded block
      logic [31:0] word;
   } sha1s_entry_type;

   function automatic logic [31:0] sha1s_round_k(input logic [ROUND_W-1:0] round);
      logic [31:0] k;
      case (round) inside
         [7'd0:7'd19]:  k = K_ROUND_0;
         [7'd20:7'd39]: k = K_ROUND_1;
         [7'd40:7'd59]: k = K_ROUND_2;
         default:       k = K_ROUND_3;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] sha1s_round_f(input logic [ROUND_W-1:0] round,
                                                 input logic [31:0] b,
                                                 input logic [31:0] c,
                                                 input logic [31:0] d);
      logic [31:0] f;
      case (round) inside
         [7'd0:7'd19]:  f = (b & c) | (~b & d);
         [7'd40:7'd59]: f = (b & c) | (b & d) | (c & d);
         default:       f = b ^ c ^ d;
      endcase
      return f;
   endfunction

   function automatic logic [7:0] sha1s_hex_char(input logic [3:0] nibble);
      logic [7:0] ch;
      if (nibble < 4'd10) begin
         ch = 8'h30 + {4'h0, nibble};
      end else begin
         ch = 8'h57 + {4'h0, nibble};
      end
      return ch;
   endfunction

endpackage

// ----- hw/rtl/sha1s_queue.sv -----
// ----------------------------------------------------------------------------
// sha1s_queue
// word queue between the byte front and the round engine
// ----------------------------------------------------------------------------
module sha1s_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  sha1s_pkg::sha1s_entry_type push_entry,
   output logic                      pop_valid,
   input  logic                      pop,
   output sha1s_pkg::sha1s_entry_type pop_entry
);
   import sha1s_pkg::*;

   sha1s_entry_type            mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]       count_ff, count_in;
   logic                       do_push, do_pop;

   assign push_ready = (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hw/rtl/sha1s_front.sv -----
// ----------------------------------------------------------------------------
// sha1s_front
// accepts bytes and finish items, packs words, generates padding and length
// ----------------------------------------------------------------------------
module sha1s_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_mode,
   input  logic [7:0]                 req_data_byte,
   output logic                       push_valid,
   input  logic                       push_ready,
   output sha1s_pkg::sha1s_entry_type push_entry
);
   import sha1s_pkg::*;

   typedef enum logic {ST_ACCEPT, ST_PAD} state_type;

   state_type    state_ff, state_in;
   logic [5:0]   fill_ff, fill_in;
   logic [60:0]  count_ff, count_in;
   logic [31:0]  word_ff, word_in;
   logic [63:0]  len_ff, len_in;
   logic [1:0]   pos_ff, pos_in;
   logic [3:0]   pad_idx_ff, pad_idx_in;
   logic         first_ff, first_in;
   logic         len_hi_ff, len_hi_in;
   logic         accept;
   logic [31:0]  packed_word;
   logic [31:0]  pad_word;

   assign req_stall = (state_ff == ST_PAD) || !push_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      packed_word = word_ff;
      case (fill_ff[1:0])
         2'd0:    packed_word[31:24] = req_data_byte;
         2'd1:    packed_word[23:16] = req_data_byte;
         2'd2:    packed_word[15:8]  = req_data_byte;
         default: packed_word[7:0]   = req_data_byte;
      endcase
      case (pos_ff)
         2'd0:    pad_word = {PAD_BYTE, 24'h0};
         2'd1:    pad_word = {word_ff[31:24], PAD_BYTE, 16'h0};
         2'd2:    pad_word = {word_ff[31:16], PAD_BYTE, 8'h0};
         default: pad_word = {word_ff[31:8], PAD_BYTE};
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      count_in   = count_ff;
      word_in    = word_ff;
      len_in     = len_ff;
      pos_in     = pos_ff;
      pad_idx_in = pad_idx_ff;
      first_in   = first_ff;
      len_hi_in  = len_hi_ff;
      push_valid = 1'b0;
      push_entry = '{last_word: 1'b0, word: packed_word};
      case (state_ff)
         ST_ACCEPT: begin
            if (accept && req_mode == MODE_DATA) begin
               word_in  = packed_word;
               fill_in  = fill_ff + 1'b1;
               count_in = count_ff + 1'b1;
               if (fill_ff[1:0] == 2'd3) begin
                  push_valid = 1'b1;
               end
            end else if (accept) begin
               len_in     = {count_ff, 3'b000};
               pos_in     = fill_ff[1:0];
               pad_idx_in = fill_ff[5:2];
               first_in   = 1'b1;
               len_hi_in  = 1'b0;
               fill_in    = '0;
               count_in   = '0;
               state_in   = ST_PAD;
            end
         end
         ST_PAD: begin
            push_valid = 1'b1;
            if (first_ff) begin
               push_entry.word = pad_word;
            end else if (pad_idx_ff == 4'd14) begin
               push_entry.word = len_ff[63:32];
            end else if (pad_idx_ff == 4'd15 && len_hi_ff) begin
               push_entry = '{last_word: 1'b1, word: len_ff[31:0]};
            end else begin
               push_entry.word = '0;
            end
            if (push_ready) begin
               pad_idx_in = pad_idx_ff + 1'b1;
               first_in   = 1'b0;
               if (!first_ff && pad_idx_ff == 4'd14) begin
                  len_hi_in = 1'b1;
               end
               if (push_entry.last_word) begin
                  state_in = ST_ACCEPT;
               end
            end
         end
         default: state_in = ST_ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_ACCEPT;
         fill_ff   <= '0;
         count_ff  <= '0;
         first_ff  <= 1'b0;
         len_hi_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         count_ff  <= count_in;
         first_ff  <= first_in;
         len_hi_ff <= len_hi_in;
      end
      word_ff    <= word_in;
      len_ff     <= len_in;
      pos_ff     <= pos_in;
      pad_idx_ff <= pad_idx_in;
   end

endmodule

// ----- hw/rtl/sha1s_back.sv -----
// ----------------------------------------------------------------------------
// sha1s_back
// round engine: one round a cycle while message words are available, chaining update and digest output
// ----------------------------------------------------------------------------
module sha1s_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       hex_output,
   input  logic                       pop_valid,
   output logic                       pop,
   input  sha1s_pkg::sha1s_entry_type pop_entry,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_digest_byte,
   output logic                       rsp_last_of_digest
);
   import sha1s_pkg::*;

   typedef enum logic [1:0] {ST_ROUND, ST_ADD, ST_OUT} state_type;

   state_type            state_ff, state_in;
   logic [ROUND_W-1:0]   round_ff, round_in;
   logic [31:0]          h_ff [5];
   logic [31:0]          h_in [5];
   logic [31:0]          v_ff [5];
   logic [31:0]          v_in [5];
   logic [31:0]          win_ff [16];
   logic [31:0]          win_in [16];
   logic                 fin_ff, fin_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [31:0]          sched, wt, tsum;
   logic                 early, step, load, last_out;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_digest_byte    = rsp_byte_ff;
   assign rsp_last_of_digest = rsp_last_ff;

   always_comb begin
      early = (round_ff < ROUND_W'(16));
      sched = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
      wt    = early ? pop_entry.word : {sched[30:0], sched[31]};
      tsum  = {v_ff[0][26:0], v_ff[0][31:27]}
            + sha1s_round_f(round_ff, v_ff[1], v_ff[2], v_ff[3])
            + v_ff[4] + sha1s_round_k(round_ff) + wt;
      step     = early ? pop_valid : 1'b1;
      load     = !rsp_valid_ff || !rsp_stall;
      last_out = hex_output ? (cnt_ff == 6'd39) : (cnt_ff == 6'd19);
   end

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      h_in         = h_ff;
      v_in         = v_ff;
      win_in       = win_ff;
      fin_in       = fin_ff;
      cnt_in       = cnt_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop          = 1'b0;
      case (state_ff)
         ST_ROUND: begin
            if (step) begin
               pop      = early;
               v_in[0]  = tsum;
               v_in[1]  = v_ff[0];
               v_in[2]  = {v_ff[1][1:0], v_ff[1][31:2]};
               v_in[3]  = v_ff[2];
               v_in[4]  = v_ff[3];
               for (int j = 0; j < 15; j++) begin
                  win_in[j] = win_ff[j+1];
               end
               win_in[15] = wt;
               if (round_ff == ROUND_W'(15)) begin
                  fin_in = pop_entry.last_word;
               end
               if (round_ff == ROUND_W'(ROUNDS - 1)) begin
                  round_in = '0;
                  state_in = ST_ADD;
               end else begin
                  round_in = round_ff + 1'b1;
               end
            end
         end
         ST_ADD: begin
            for (int j = 0; j < 5; j++) begin
               h_in[j] = h_ff[j] + v_ff[j];
               v_in[j] = h_ff[j] + v_ff[j];
            end
            cnt_in   = '0;
            state_in = fin_ff ? ST_OUT : ST_ROUND;
         end
         ST_OUT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = last_out;
               cnt_in       = cnt_ff + 1'b1;
               if (!hex_output) begin
                  rsp_byte_in = h_ff[0][31:24];
               end else if (cnt_ff[0]) begin
                  rsp_byte_in = sha1s_hex_char(h_ff[0][27:24]);
               end else begin
                  rsp_byte_in = sha1s_hex_char(h_ff[0][31:28]);
               end
               // digest bytes shift after each raw byte, or once both hex characters have gone out
               if (!hex_output || cnt_ff[0]) begin
                  for (int j = 0; j < 4; j++) begin
                     h_in[j] = {h_ff[j][23:0], h_ff[j+1][31:24]};
                  end
                  h_in[4] = {h_ff[4][23:0], 8'h00};
               end
               if (last_out) begin
                  h_in     = SHA1S_INIT;
                  v_in     = SHA1S_INIT;
                  state_in = ST_ROUND;
               end
            end
         end
         default: state_in = ST_ROUND;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ROUND;
         round_ff     <= '0;
         h_ff         <= SHA1S_INIT;
         v_ff         <= SHA1S_INIT;
         fin_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         h_ff         <= h_in;
         v_ff         <= v_in;
         fin_ff       <= fin_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      win_ff      <= win_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ----- hw/rtl/sha1_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// sha-1 digest of a byte stream, digest out as raw bytes or hex characters
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  req      in         valid / stall      req_mode, req_data_byte
//  rsp      out        valid / stall      rsp_digest_byte, rsp_last_of_digest
//  csr      in         valid / ready      csr_hex_output
//
//  a data byte transfer goes through while the word queue has room
//  each 64-byte block runs through all 80 rounds of the round engine, then
//  the chaining add, before the engine takes words of the next block
//  a finish transfer stalls req while 3 to 18 padding words go out; the
//  digest follows after one or two blocks, then 20 or 40 rsp transfers
//  synchronous reset, no clearing pass; csr is always ready
//  rsp has an output register; rsp stalls hold the engine, req once queue fills
//
module sha1_stream_hasher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_digest_byte,
   output logic       rsp_last_of_digest,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_hex_output
);
   import sha1s_pkg::*;

   // hex output mode register
   logic            hex_ff;

   // word transfers from front into the queue and out to the round engine
   logic            push_valid;
   logic            push_ready;
   sha1s_entry_type push_entry;
   logic            pop_valid;
   logic            pop;
   sha1s_entry_type pop_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hex_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         hex_ff <= csr_hex_output;
      end
   end

   // front: byte packing, length count, padding sequencer
   sha1s_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_entry    (push_entry)
   );

   // one block of words of slack so the front runs ahead of the rounds
   sha1s_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   // back: rounds, chaining words and digest output
   sha1s_back u_back (
      .clock              (clock),
      .reset              (reset),
      .hex_output         (hex_ff),
      .pop_valid          (pop_valid),
      .pop                (pop),
      .pop_entry          (pop_entry),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_byte    (rsp_digest_byte),
      .rsp_last_of_digest (rsp_last_of_digest)
   );

endmodule

// ----- hw/rtl/sha1s_checker.sv -----
// ----------------------------------------------------------------------------
// sha1s_checker
// port-level checks of the sha-1 stream hasher, bound to the top level
// ----------------------------------------------------------------------------
module sha1s_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_mode,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_digest_byte,
   input logic       rsp_last_of_digest
);
   import sha1s_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digest_byte)
                                 && $stable(rsp_last_of_digest))
      else $error("rsp payload changed under stall");

   // nothing comes out right after reset
   a_rsp_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // a finish transfer starts padding, which holds off the next item
   a_finish_pad: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == MODE_FINISH |=> req_stall ##1 req_stall)
      else $error("req taken during padding");

endmodule

bind sha1_stream_hasher sha1s_checker u_sha1s_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_mode           (req_mode),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_digest_byte    (rsp_digest_byte),
   .rsp_last_of_digest (rsp_last_of_digest)
);
